FILE: hw/rtl/teg_pkg.sv
// shared types and constants for the trapezoid envelope generator
// no dependencies; imported by teg_serial_div and trapezoid_envelope_generator
package teg_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE_TIME = 2'd0,
    CFG_HOLD_TIME = 2'd1,
    CFG_FALL_TIME = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FUNC_TRIGGER = 1'b0,
    FUNC_TICK    = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_TRIG_HOLD,
    S_TRIG_FALL,
    S_SCALE,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               in_window;
  } out_item_t;

endpackage

FILE: hw/rtl/trapezoid_envelope_generator.sv
// trapezoid envelope generator top level: config registers, envelope state, sequencer
// depends on teg_pkg and teg_serial_div
//
// usage:
//   input channel carries items {func, now}; func = trigger starts an envelope at
//   now, func = tick asks for the level at now. each item gives one result item
//   {level, in_window} on the output channel, in order.
//   configuration: cfg_we_i writes cfg_wdata_i to rise, hold or fall time at
//   cfg_idx_i; user must write only while no item is in flight; not enforced.
// states from input accept to output valid:
//   ramp tick: compare, scale, the 8-step bit-serial divider (one quotient
//   bit per cycle) and output states
//   trigger: eval, trig_hold and trig_fall states, one 32-bit phase-end add each,
//   then output; other ticks: eval then output
// throughput: one item at a time; the next item is taken as soon as the
//   previous result sits in the output register, even if it is not yet taken.
// reset: envelope inactive, all times and phase ends zero, no item pending.
// a stalled receiver holds the result in the output register; the block then
//   finishes at most one more item and waits for the register to drain.
module trapezoid_envelope_generator
  import teg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TIME_W-1:0]    cfg_wdata_i
);

  state_e            state_q, state_d;
  logic [TIME_W-1:0] rise_time_q, hold_time_q, fall_time_q;

  in_item_t          item_q, item_d;
  logic              running_q, running_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [TIME_W-1:0] rise_end_q, rise_end_d;
  logic [TIME_W-1:0] hold_end_q, hold_end_d;
  logic [TIME_W-1:0] fall_end_q, fall_end_d;
  logic [TIME_W-1:0] num_q, num_d;
  logic [TIME_W-1:0] span_q, span_d;
  logic              fall_q, fall_d;
  out_item_t         res_q, res_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic               win;
  logic               div_start;
  logic               div_done;
  logic [LEVEL_W-1:0] quot;

  teg_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .span_i  (span_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign win = running_q && (item_q.now >= start_q) && (item_q.now <= fall_end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_time_q <= '0;
      hold_time_q <= '0;
      fall_time_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RISE_TIME: rise_time_q <= cfg_wdata_i;
        CFG_HOLD_TIME: hold_time_q <= cfg_wdata_i;
        CFG_FALL_TIME: fall_time_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    running_d   = running_q;
    start_d     = start_q;
    rise_end_d  = rise_end_q;
    hold_end_d  = hold_end_q;
    fall_end_d  = fall_end_q;
    num_d       = num_q;
    span_d      = span_q;
    fall_d      = fall_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_start   = 1'b0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        res_d.in_window = win;
        res_d.level     = '0;
        if (item_q.func == FUNC_TRIGGER) begin
          running_d  = 1'b1;
          start_d    = item_q.now;
          rise_end_d = item_q.now + rise_time_q;
          state_d    = S_TRIG_HOLD;
        end else if (!win) begin
          state_d = S_OUT;
        end else if (item_q.now < rise_end_q) begin
          num_d   = item_q.now - start_q;
          span_d  = rise_end_q - start_q;
          fall_d  = 1'b0;
          state_d = S_SCALE;
        end else if (item_q.now < hold_end_q) begin
          res_d.level = LEVEL_FULL;
          state_d     = S_OUT;
        end else if (item_q.now < fall_end_q) begin
          num_d   = item_q.now - hold_end_q;
          span_d  = fall_end_q - hold_end_q;
          fall_d  = 1'b1;
          state_d = S_SCALE;
        end else begin
          running_d = 1'b0;
          state_d   = S_OUT;
        end
      end
      S_TRIG_HOLD: begin
        hold_end_d = rise_end_q + hold_time_q;
        state_d    = S_TRIG_FALL;
      end
      S_TRIG_FALL: begin
        fall_end_d = hold_end_q + fall_time_q;
        state_d    = S_OUT;
      end
      S_SCALE: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          res_d.level = fall_q ? (LEVEL_FULL - quot) : quot;
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= 1'b0;
      start_q     <= '0;
      rise_end_q  <= '0;
      hold_end_q  <= '0;
      fall_end_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      start_q     <= start_d;
      rise_end_q  <= rise_end_d;
      hold_end_q  <= hold_end_d;
      fall_end_q  <= fall_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    num_q  <= num_d;
    span_q <= span_d;
    fall_q <= fall_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_level_needs_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.in_window || out_q.level == '0))
    else $error("nonzero level outside the envelope window");

  a_accept_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_EVAL)
    else $error("accepted item not evaluated next cycle");

  a_trigger_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL && item_q.func == FUNC_TRIGGER |=> running_q)
    else $error("trigger did not start the envelope");

endmodule

FILE: hw/rtl/teg_serial_div.sv
// bit-serial restoring divider: quotient of (num * 255) / span, one bit per cycle
// depends on teg_pkg; the quotient is known to fit in LEVEL_W bits
module teg_serial_div
  import teg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [TIME_W-1:0]  num_i,
  input  logic [TIME_W-1:0]  span_i,
  output logic               done_o,
  output logic [LEVEL_W-1:0] quot_o
);

  localparam int unsigned CNT_W  = $clog2(LEVEL_W);
  localparam int unsigned PROD_W = TIME_W + LEVEL_W;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TIME_W-1:0]  rem_q, rem_d;
  logic [LEVEL_W-1:0] lo_q, lo_d;
  logic [LEVEL_W-1:0] quot_q, quot_d;
  logic [TIME_W-1:0]  span_q, span_d;

  logic [PROD_W-1:0]  prod;
  logic [TIME_W:0]    trial;
  logic [TIME_W:0]    diff;
  logic               ge;

  // num * 255 = (num << 8) - num
  assign prod  = {num_i, LEVEL_W'(0)} - PROD_W'(num_i);
  assign trial = {rem_q, lo_q[LEVEL_W-1]};
  assign diff  = trial - {1'b0, span_q};
  assign ge    = trial >= {1'b0, span_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    span_d = span_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(LEVEL_W - 1);
      rem_d  = prod[PROD_W-1:LEVEL_W];
      lo_d   = prod[LEVEL_W-1:0];
      span_d = span_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      lo_d   = {lo_q[LEVEL_W-2:0], 1'b0};
      quot_d = {quot_q[LEVEL_W-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
    span_q <= span_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
